// ===== hdl/bsr_pkg.sv =====
`default_nettype none

package bsr_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// Field widths of the size registers and the config data path
	localparam int SIZE_W = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int PIX_W  = 8;

	localparam logic [PIX_W-1:0] PIX_FG   = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [PIX_W-1:0]  pix_t;

	localparam size_t MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
	localparam size_t MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_EIGHT = 2'd1,
		MODE_EDGE  = 2'd2,
		MODE_DIAG  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	// Line store access for one cycle
	typedef struct packed {
		logic rd_en;
		col_t rd_addr;
		logic wr_en;
		col_t wr_addr;
	} ls_req_t;

	// Frame border flags of the pixel leaving the window
	typedef struct packed {
		logic n_ok;
		logic s_ok;
		logic w_ok;
		logic e_ok;
		logic last;
	} border_t;

	function automatic size_t clamp_size(input size_t v, input size_t hi);
		size_t r;
		if (v == '0)
			r = size_t'(1);
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/binary_spur_removal_pass.sv =====
// Timing: the word that completes a 3x3 window waits in the stage 1 register; its result
// enters the output register as stage 1 advances. The pixel itself leaves one row plus one pixel behind.
// Throughput: one word per clock unless the output stalls, set by the single read and write slot of the line stores.
// Flush words during a frame are taken and dropped; after the last row W+1 words drain.
// Reset: counters, window and config return to defaults at once; the line stores need no clearing.
`default_nettype none

module binary_spur_removal_pass (
	input  wire                clk,
	input  wire                arst_n,
	// configuration write port
	input  wire                cfg_we,
	input  wire [1:0]          cfg_index,
	input  bsr_pkg::size_t     cfg_data,
	// pixel input channel
	input  wire                in_valid,
	output logic               in_ready,
	input  bsr_pkg::pix_t      pixel_in,
	input  wire                flush,
	// result channel
	output logic               out_valid,
	input  wire                out_ready,
	output bsr_pkg::pix_t      pixel_out,
	output logic               removed,
	output logic               last_pixel,
	output logic               frame_changed
);
	import bsr_pkg::*;

	// ---------------- configuration ----------------
	mode_t mode_q;
	size_t width_q;
	size_t height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_EIGHT;
			width_q  <= MAX_W_SIZE;
			height_q <= MAX_H_SIZE;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// ---------------- input side: counters and position ----------------
	col_t  in_col_q;
	size_t in_row_q;
	col_t  out_col_q;
	row_t  out_row_q;

	size_t   w_eff;
	size_t   h_eff;
	logic    draining;
	logic    accept;
	logic    load;
	logic    emit_in;
	logic    in_row_end;
	border_t border_in;

	// stage 1 registers
	logic    valid_s1;
	logic    emit_s1;
	pix_t    pix_s1;
	col_t    col_s1;
	border_t border_s1;

	logic    go_s1;

	always_comb begin
		w_eff      = clamp_size(width_q, MAX_W_SIZE);
		h_eff      = clamp_size(height_q, MAX_H_SIZE);
		draining   = in_row_q >= h_eff;
		accept     = in_valid && in_ready;
		// a flush word inside the frame carries nothing: take it and drop it
		load       = accept && (draining || !flush);
		emit_in    = (in_row_q >= size_t'(2)) ||
		             ((in_row_q == size_t'(1)) && (in_col_q != '0));
		in_row_end = (size_t'(in_col_q) + size_t'(1)) >= w_eff;

		// border flags of the pixel that leaves the window with this word
		border_in.n_ok = out_row_q != '0;
		border_in.s_ok = (size_t'(out_row_q) + size_t'(1)) < h_eff;
		border_in.w_ok = out_col_q != '0;
		border_in.e_ok = (size_t'(out_col_q) + size_t'(1)) < w_eff;
		border_in.last = !border_in.s_ok && !border_in.e_ok;
	end

	// stage 1 moves on unless it holds a result and the output register is blocked
	assign go_s1    = !valid_s1 || !emit_s1 || !out_valid || out_ready;
	assign in_ready = go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (load) begin
			if (emit_in && border_in.last) begin
				// frame done: restart every counter for the next frame
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_row_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + size_t'(1);
				end else begin
					in_col_q <= in_col_q + col_t'(1);
				end
				if (emit_in) begin
					if (!border_in.e_ok) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + row_t'(1);
					end else begin
						out_col_q <= out_col_q + col_t'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go_s1) begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			emit_s1   <= emit_in;
			pix_s1    <= draining ? PIX_ZERO : pixel_in;
			col_s1    <= in_col_q;
			border_s1 <= border_in;
		end
	end

	// ---------------- line stores ----------------
	ls_req_t ls_req;
	pix_t    upper_col;
	pix_t    middle_col;
	logic    adv_s1;

	assign adv_s1 = valid_s1 && go_s1;

	always_comb begin
		ls_req.rd_en   = load;
		ls_req.rd_addr = in_col_q;
		ls_req.wr_en   = adv_s1;
		ls_req.wr_addr = col_s1;
	end

	bsr_line_store u_line_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (ls_req),
		.wr_pix     (pix_s1),
		.upper_col  (upper_col),
		.middle_col (middle_col)
	);

	// ---------------- window and spur decision ----------------
	pix_t win_q [9];
	pix_t win_nx [9];

	logic [2:0] edges;
	logic [2:0] diags;
	logic [3:0] count;
	logic       rem;

	always_comb begin
		// shift left, new column on the right
		win_nx[0] = win_q[1];
		win_nx[1] = win_q[2];
		win_nx[2] = upper_col;
		win_nx[3] = win_q[4];
		win_nx[4] = win_q[5];
		win_nx[5] = middle_col;
		win_nx[6] = win_q[7];
		win_nx[7] = win_q[8];
		win_nx[8] = pix_s1;

		edges = 3'(border_s1.n_ok && (win_nx[1] == PIX_FG)) +
		        3'(border_s1.s_ok && (win_nx[7] == PIX_FG)) +
		        3'(border_s1.w_ok && (win_nx[3] == PIX_FG)) +
		        3'(border_s1.e_ok && (win_nx[5] == PIX_FG));
		diags = 3'(border_s1.n_ok && border_s1.w_ok && (win_nx[0] == PIX_FG)) +
		        3'(border_s1.n_ok && border_s1.e_ok && (win_nx[2] == PIX_FG)) +
		        3'(border_s1.s_ok && border_s1.w_ok && (win_nx[6] == PIX_FG)) +
		        3'(border_s1.s_ok && border_s1.e_ok && (win_nx[8] == PIX_FG));

		case (mode_q)
			MODE_EIGHT: count = 4'(edges) + 4'(diags);
			MODE_EDGE:  count = 4'(edges);
			MODE_DIAG:  count = 4'(diags);
			default:    count = '0;
		endcase

		// mode none leaves count at zero, so nothing is removed
		rem = (win_nx[4] != PIX_ZERO) && (count == 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= PIX_ZERO;
			end
		end else if (adv_s1) begin
			win_q <= win_nx;
		end
	end

	// ---------------- output register ----------------
	logic any_removed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid     <= 1'b0;
			any_removed_q <= 1'b0;
		end else begin
			if (adv_s1 && emit_s1) begin
				out_valid     <= 1'b1;
				// clear the change flag once the frame's final word is out
				any_removed_q <= border_s1.last ? 1'b0 : (any_removed_q || rem);
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			pixel_out     <= rem ? PIX_ZERO : win_nx[4];
			removed       <= rem;
			last_pixel    <= border_s1.last;
			frame_changed <= border_s1.last && (any_removed_q || rem);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bsr_line_store.sv =====
`default_nettype none

module bsr_line_store (
	input  wire              clk,
	input  wire              arst_n,
	input  bsr_pkg::ls_req_t req,
	input  bsr_pkg::pix_t    wr_pix,
	output bsr_pkg::pix_t    upper_col,
	output bsr_pkg::pix_t    middle_col
);
	import bsr_pkg::*;

	pix_t upper_mem  [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];

	pix_t upper_rd_q;
	pix_t middle_rd_q;
	pix_t last_mid_q;
	pix_t last_pix_q;
	logic fwd_q;

	// A read that hits the entry written in the same cycle takes the new data
	always_comb begin
		upper_col  = fwd_q ? last_mid_q : upper_rd_q;
		middle_col = fwd_q ? last_pix_q : middle_rd_q;
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			upper_rd_q  <= upper_mem[req.rd_addr];
			middle_rd_q <= middle_mem[req.rd_addr];
		end
		if (req.wr_en) begin
			upper_mem[req.wr_addr]  <= middle_col;
			middle_mem[req.wr_addr] <= wr_pix;
			last_mid_q              <= middle_col;
			last_pix_q              <= wr_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (req.rd_en) begin
			fwd_q <= req.wr_en && (req.wr_addr == req.rd_addr);
		end
	end

endmodule

`default_nettype wire

// ===== tb/binary_spur_removal_pass_tb.sv =====
`timescale 1ns / 100ps

module binary_spur_removal_pass_tb;
	import bsr_pkg::*;

	localparam int RANDOM_WORDS  = 180;  // small frames; the tall frame adds 1026 more plus its stray flushes
	localparam int SETTLE_CYCLES = 8;    // output register plus a little slack
	localparam int STALL_LEN     = 300;
	localparam int WATCHDOG      = 4000;

	// one input word and one result word as the channels carry them
	typedef struct packed {
		pix_t pixel;
		logic flush;
	} pix_word_t;

	typedef struct packed {
		pix_t pixel;
		logic removed;
		logic last;
		logic changed;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MODE;
	size_t       cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	pix_t        pixel_in = PIX_ZERO;
	logic        flush = 1'b0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	pix_t        pixel_out;
	logic        removed;
	logic        last_pixel;
	logic        frame_changed;

	binary_spur_removal_pass dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_in      (pixel_in),
		.flush         (flush),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_out     (pixel_out),
		.removed       (removed),
		.last_pixel    (last_pixel),
		.frame_changed (frame_changed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// ------------------------------------------------------------------
	// Spur predictor: own copy of the registers, line stores, 3x3 window
	// and the input and output raster counters.
	// ------------------------------------------------------------------
	mode_t       cur_mode   = MODE_EIGHT;
	size_t       width_reg  = MAX_W_SIZE;
	size_t       height_reg = MAX_H_SIZE;
	pix_t        row_two_up [MAX_WIDTH];
	pix_t        row_one_up [MAX_WIDTH];
	pix_t        win [9] = '{default: PIX_ZERO};
	int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
	bit          any_cleared = 1'b0;

	pix_word_t   words_to_send[$];
	result_t     expected_pixels[$];

	int          mismatches = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          stall_requests = 0;

	function automatic int eff_size(size_t v, int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	// Advance the predictor by one accepted word; queue the result it releases.
	function automatic void spur_predict(pix_t pix, logic is_flush);
		int unsigned w, h, col, r, c, edges, diags, cnt;
		bit          drain, emit, n_ok, s_ok, w_ok, e_ok, rem, last;
		pix_t        fresh, center;
		result_t     res;
		int          k;

		w = eff_size(width_reg, MAX_WIDTH);
		h = eff_size(height_reg, MAX_HEIGHT);
		drain = (in_row >= h);
		// a flush while the frame still owes pixels is dropped outright
		if (!drain && is_flush)
			return;
		fresh = drain ? PIX_ZERO : pix;
		col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);

		// shift the window left and bring the new column in on the right
		for (k = 0; k < 3; k++) begin
			win[k * 3]     = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = row_two_up[col];
		win[5] = row_one_up[col];
		win[8] = fresh;
		row_two_up[col] = row_one_up[col];
		row_one_up[col] = fresh;

		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row++;
		end else begin
			in_col++;
		end

		if (!emit)
			return;

		r = out_row;
		c = out_col;
		n_ok = (r > 0);
		s_ok = (r + 1 < h);
		w_ok = (c > 0);
		e_ok = (c + 1 < w);
		center = win[4];

		// neighbours off the frame never count
		edges = 0;
		diags = 0;
		if (n_ok && win[1] == PIX_FG) edges++;
		if (s_ok && win[7] == PIX_FG) edges++;
		if (w_ok && win[3] == PIX_FG) edges++;
		if (e_ok && win[5] == PIX_FG) edges++;
		if (n_ok && w_ok && win[0] == PIX_FG) diags++;
		if (n_ok && e_ok && win[2] == PIX_FG) diags++;
		if (s_ok && w_ok && win[6] == PIX_FG) diags++;
		if (s_ok && e_ok && win[8] == PIX_FG) diags++;

		case (cur_mode)
			MODE_EIGHT: cnt = edges + diags;
			MODE_EDGE:  cnt = edges;
			MODE_DIAG:  cnt = diags;
			default:    cnt = 0;
		endcase

		rem = (cur_mode != MODE_NONE) && (center != PIX_ZERO) && (cnt == 1);
		if (rem)
			any_cleared = 1'b1;
		last = (r + 1 >= h) && (c + 1 >= w);

		res.pixel   = rem ? PIX_ZERO : center;
		res.removed = rem;
		res.last    = last;
		res.changed = last && any_cleared;
		expected_pixels = {expected_pixels, res};

		// the final result of a frame rearms every counter
		if (last) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			any_cleared = 1'b0;
		end else if (c + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: feed words from the pending queue, idling at random.
	// Hold valid and payload until the word is taken.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				spur_predict(pixel_in, flush);
			if (!in_valid || in_ready) begin : next_word
				pix_word_t wd;
				if (words_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					wd = words_to_send.pop_front();
					in_valid <= 1'b1;
					pixel_in <= wd.pixel;
					flush    <= wd.flush;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each taken result with the oldest expectation.
	// A hold-off request stalls the receiver.
	// ------------------------------------------------------------------
	int stalls_done = 0;
	int hold_left = 0;

	always @(posedge clk) begin : rx_side
		result_t want;
		if (out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$error("result with nothing expected: pixel_out %0h removed %0b last_pixel %0b",
					pixel_out, removed, last_pixel);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_out !== want.pixel) begin
					$error("pixel_out expected %0h got %0h", want.pixel, pixel_out);
					mismatches++;
				end
				if (removed !== want.removed) begin
					$error("removed expected %0b got %0b", want.removed, removed);
					mismatches++;
				end
				if (last_pixel !== want.last) begin
					$error("last_pixel expected %0b got %0b", want.last, last_pixel);
					mismatches++;
				end
				if (frame_changed !== want.changed) begin
					$error("frame_changed expected %0b got %0b", want.changed, frame_changed);
					mismatches++;
				end
			end
		end

		if (stall_requests != stalls_done) begin
			stalls_done++;
			hold_left = STALL_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: give up after too many cycles with no word moving.
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_word(pix_t p, logic f);
		pix_word_t wd;
		wd.pixel = p;
		wd.flush = f;
		words_to_send = {words_to_send, wd};
	endtask

	// Block the sequencer until every word is taken and every result back,
	// then let the pipeline settle. Check on the falling edge to stay clear
	// of the driver's updates.
	task automatic wait_idle();
		@(negedge clk);
		while (words_to_send.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write one register and mirror it into the predictor; lower cfg_we after the batch.
	task automatic write_reg(reg_idx_t idx, size_t val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_MODE:   cur_mode = mode_t'(val[1:0]);
			REG_WIDTH:  width_reg = val;
			REG_HEIGHT: height_reg = val;
			default:    ;
		endcase
	endtask

	task automatic set_frame(mode_t m, size_t w, size_t h);
		wait_idle();
		write_reg(REG_MODE, size_t'(m));
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Queue one whole frame plus its drain; return how many words count.
	task automatic queue_frame(int fg_pct, int noise_pct, output int n);
		int w, h, i, roll;
		w = eff_size(width_reg, MAX_WIDTH);
		h = eff_size(height_reg, MAX_HEIGHT);
		n = 0;
		for (i = 0; i < w * h; i++) begin
			// stray flush inside the frame: the block must drop it
			if ($urandom_range(99) < noise_pct)
				push_word(pix_t'($urandom), 1'b1);
			roll = $urandom_range(99);
			if (roll < fg_pct)
				push_word(PIX_FG, 1'b0);
			else if (roll < fg_pct + 12)
				push_word(pix_t'($urandom), 1'b0);
			else
				push_word(PIX_ZERO, 1'b0);
			n++;
		end
		// drain: a plain pixel here acts as a flush too
		for (i = 0; i <= w; i++) begin
			push_word(pix_t'($urandom), ($urandom_range(3) != 0));
			n++;
		end
	endtask

	initial begin : sequencer
		int    counted, n, frame_no;
		bit    big;
		size_t w, h;

		counted = 0;
		frame_no = 0;
		tx_idle_pct = 20;
		rx_idle_pct = 61;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a 3x2 frame with two spurs, a dropped flush mid frame,
		// a non-foreground nonzero pixel and a pixel used as a drain word.
		set_frame(MODE_EIGHT, 11'd3, 11'd2);
		push_word(PIX_FG, 1'b0);
		push_word(PIX_FG, 1'b0);
		push_word(PIX_FG, 1'b1);
		push_word(PIX_ZERO, 1'b0);
		push_word(8'h80, 1'b0);
		push_word(PIX_ZERO, 1'b0);
		push_word(PIX_FG, 1'b0);
		push_word(PIX_ZERO, 1'b1);
		push_word(PIX_FG, 1'b0);
		push_word(PIX_ZERO, 1'b1);
		push_word(PIX_FG, 1'b1);

		// zero sizes clamp to a single pixel; this mode removes nothing
		set_frame(MODE_NONE, 11'd0, 11'd0);
		push_word(PIX_FG, 1'b0);
		push_word(PIX_ZERO, 1'b1);
		push_word(PIX_FG, 1'b1);

		// two foreground pixels side by side: edge mode clears both
		set_frame(MODE_EDGE, 11'd2, 11'd1);
		push_word(PIX_FG, 1'b0);
		push_word(PIX_FG, 1'b0);
		repeat (3) push_word(PIX_ZERO, 1'b1);

		// same pair with diagonals only: nothing to clear
		set_frame(MODE_DIAG, 11'd2, 11'd1);
		push_word(PIX_FG, 1'b0);
		push_word(PIX_FG, 1'b0);
		repeat (3) push_word(PIX_ZERO, 1'b1);

		// Random frames. Run three idling phases over small frames, plus
		// one oversized height that clamps; its words are not counted here.
		while (counted < RANDOM_WORDS) begin
			if (counted < RANDOM_WORDS / 3) begin
				tx_idle_pct = 20;
				rx_idle_pct = 61;
			end else if (counted < 2 * RANDOM_WORDS / 3) begin
				tx_idle_pct = 61;
				rx_idle_pct = 20;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			big = (frame_no == 3);
			if (big || $urandom_range(99) < 60) begin
				if (big) begin
					w = 11'd1;
					h = 11'h7FF;
				end else begin
					w = ($urandom_range(19) == 0) ? size_t'(0) : size_t'($urandom_range(12, 1));
					h = ($urandom_range(19) == 0) ? size_t'(0) : size_t'($urandom_range(8, 1));
				end
				set_frame(mode_t'($urandom_range(3)), w, h);
			end

			// long receiver hold-off while the tall frame streams in
			if (big)
				stall_requests++;

			// a flush between frames is dropped as well
			if ($urandom_range(9) == 0)
				push_word(pix_t'($urandom), 1'b1);

			queue_frame($urandom_range(80, 20), 4, n);
			if (!big)
				counted += n;
			frame_no++;
		end

		wait_idle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
